// File: rtl/tpsc_pkg.sv
// Shared types, constants and microcode for the two-wheel PI speed controller.
package tpsc_pkg;

  // item kinds
  localparam logic [1:0] OP_ENC   = 2'd0;
  localparam logic [1:0] OP_TWIST = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register map
  localparam int REG_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KP2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KI2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV = 3'd5;

  localparam logic [REG_W-1:0] KP1_RST = 24'd6554;
  localparam logic [REG_W-1:0] KI1_RST = 24'd13107;
  localparam logic [REG_W-1:0] KP2_RST = 24'd39322;
  localparam logic [REG_W-1:0] KI2_RST = 24'd26214;
  localparam logic [REG_W-1:0] HT_RST  = 24'd8520;
  localparam logic [REG_W-1:0] INV_RST = 24'd1310720;

  // field widths
  localparam int DELTA_W = 16;
  localparam int SPEED_W = 32;
  localparam int OUT_W   = 9;

  // shared multiplier: signed A, unsigned B, signed 64-bit product
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 30;
  localparam int PROD_W  = 64;

  // pi/18 scaled by 2^32
  localparam logic [MUL_B_W-1:0] PI18_Q32 = 30'd749613206;

  // multiplier A operand select
  localparam logic [2:0] ASEL_NONE = 3'd0;
  localparam logic [2:0] ASEL_D1   = 3'd1;
  localparam logic [2:0] ASEL_D2   = 3'd2;
  localparam logic [2:0] ASEL_W    = 3'd3;
  localparam logic [2:0] ASEL_OPA  = 3'd4;
  localparam logic [2:0] ASEL_ERR1 = 3'd5;
  localparam logic [2:0] ASEL_ERR2 = 3'd6;

  // multiplier B operand select
  localparam logic [2:0] BSEL_NONE = 3'd0;
  localparam logic [2:0] BSEL_PI   = 3'd1;
  localparam logic [2:0] BSEL_HT   = 3'd2;
  localparam logic [2:0] BSEL_INV  = 3'd3;
  localparam logic [2:0] BSEL_KP1  = 3'd4;
  localparam logic [2:0] BSEL_KI1  = 3'd5;
  localparam logic [2:0] BSEL_KP2  = 3'd6;
  localparam logic [2:0] BSEL_KI2  = 3'd7;

  // register write select
  localparam logic [3:0] WR_NONE    = 4'd0;
  localparam logic [3:0] WR_MEAS1   = 4'd1;
  localparam logic [3:0] WR_MEAS2   = 4'd2;
  localparam logic [3:0] WR_TURN    = 4'd3;
  localparam logic [3:0] WR_OPA_ADD = 4'd4;
  localparam logic [3:0] WR_OPA_SUB = 4'd5;
  localparam logic [3:0] WR_TGT1    = 4'd6;
  localparam logic [3:0] WR_TGT2    = 4'd7;
  localparam logic [3:0] WR_ERR     = 4'd8;
  localparam logic [3:0] WR_INT1    = 4'd9;
  localparam logic [3:0] WR_INT2    = 4'd10;
  localparam logic [3:0] WR_ACC1    = 4'd11;
  localparam logic [3:0] WR_ACC2    = 4'd12;

  // drive capture select
  localparam logic [1:0] DRV_NONE = 2'd0;
  localparam logic [1:0] DRV_ONE  = 2'd1;
  localparam logic [1:0] DRV_TWO  = 2'd2;

  // sequencing
  localparam logic [1:0] SEQ_NEXT = 2'd0;
  localparam logic [1:0] SEQ_END  = 2'd1;
  localparam logic [1:0] SEQ_EMIT = 2'd2;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ENTRY_ENC   = 5'd0;
  localparam pc_t ENTRY_TWIST = 5'd3;
  localparam pc_t ENTRY_TICK  = 5'd9;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       mul_en;
    logic       sh_enc;
    logic [3:0] wr;
    logic [1:0] drv;
    logic [1:0] seq;
  } ctl_t;

  localparam ctl_t UC_NOP = '{a_sel: ASEL_NONE, b_sel: BSEL_NONE, mul_en: 1'b0,
                              sh_enc: 1'b0, wr: WR_NONE, drv: DRV_NONE,
                              seq: SEQ_END};

  function automatic ctl_t uc(input logic [2:0] a, input logic [2:0] b,
                              input logic sh, input logic [3:0] wr,
                              input logic [1:0] drv, input logic [1:0] seq);
    ctl_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.mul_en = (a != ASEL_NONE);
    w.sh_enc = sh;
    w.wr     = wr;
    w.drv    = drv;
    w.seq    = seq;
    return w;
  endfunction

  // microprogram; the product register is read by the step after the one that loads it
  function automatic ctl_t ucode_rom(input pc_t pc);
    ctl_t w;
    case (pc)
      // encoder
      5'd0:  w = uc(ASEL_D1,   BSEL_PI,   1'b0, WR_NONE,    DRV_NONE, SEQ_NEXT);
      5'd1:  w = uc(ASEL_D2,   BSEL_PI,   1'b1, WR_MEAS1,   DRV_NONE, SEQ_NEXT);
      5'd2:  w = uc(ASEL_NONE, BSEL_NONE, 1'b1, WR_MEAS2,   DRV_NONE, SEQ_END);
      // twist
      5'd3:  w = uc(ASEL_W,    BSEL_HT,   1'b0, WR_NONE,    DRV_NONE, SEQ_NEXT);
      5'd4:  w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_TURN,    DRV_NONE, SEQ_NEXT);
      5'd5:  w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_OPA_ADD, DRV_NONE, SEQ_NEXT);
      5'd6:  w = uc(ASEL_OPA,  BSEL_INV,  1'b0, WR_OPA_SUB, DRV_NONE, SEQ_NEXT);
      5'd7:  w = uc(ASEL_OPA,  BSEL_INV,  1'b0, WR_TGT1,    DRV_NONE, SEQ_NEXT);
      5'd8:  w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_TGT2,    DRV_NONE, SEQ_END);
      // tick, wheel two overlaps wheel one on the multiplier
      5'd9:  w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_ERR,     DRV_NONE, SEQ_NEXT);
      5'd10: w = uc(ASEL_ERR1, BSEL_KI1,  1'b0, WR_NONE,    DRV_NONE, SEQ_NEXT);
      5'd11: w = uc(ASEL_ERR1, BSEL_KP1,  1'b0, WR_INT1,    DRV_NONE, SEQ_NEXT);
      5'd12: w = uc(ASEL_ERR2, BSEL_KI2,  1'b0, WR_ACC1,    DRV_NONE, SEQ_NEXT);
      5'd13: w = uc(ASEL_ERR2, BSEL_KP2,  1'b0, WR_INT2,    DRV_ONE,  SEQ_NEXT);
      5'd14: w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_ACC2,    DRV_NONE, SEQ_NEXT);
      5'd15: w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_NONE,    DRV_TWO,  SEQ_NEXT);
      5'd16: w = uc(ASEL_NONE, BSEL_NONE, 1'b0, WR_NONE,    DRV_NONE, SEQ_EMIT);
      default: w = UC_NOP;
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(input logic [1:0] op);
    pc_t pc;
    case (op)
      OP_ENC:   pc = ENTRY_ENC;
      OP_TWIST: pc = ENTRY_TWIST;
      default:  pc = ENTRY_TICK;
    endcase
    return pc;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v[PROD_W-1:31] != {(PROD_W-31){v[PROD_W-1]}}) begin
      r = v[PROD_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/tpsc_seq.sv
// Microcode sequencer: step counter, control ROM and dispatch.
module tpsc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       op,
  input  logic             out_hold,
  output tpsc_pkg::ctl_t   ctl,
  output logic             busy,
  output logic             emit
);
  import tpsc_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic busy_r, busy_nxt;
  ctl_t word;

  assign word = ucode_rom(pc_r);
  assign ctl  = busy_r ? word : UC_NOP;
  assign busy = busy_r;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    emit     = 1'b0;
    if (busy_r) begin
      unique case (word.seq)
        SEQ_NEXT: pc_nxt = pc_r + pc_t'(1);
        SEQ_END:  busy_nxt = 1'b0;
        SEQ_EMIT: begin
          // hold here until the output register is free
          if (!out_hold) begin
            emit     = 1'b1;
            busy_nxt = 1'b0;
          end
        end
        default:  busy_nxt = 1'b0;
      endcase
    end else if (start) begin
      pc_nxt   = entry_pc(op);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// File: rtl/two_wheel_pi_speed_controller_unit.sv
// Two-wheel PI speed controller: top level with datapath, config and output register.
// One word at a time. Encoder word: 3 steps, twist word: 6, tick word: 8 microcode steps;
// the next word is accepted once the last step has ended.
// All products go through one registered 33x30 multiplier.
// A tick result is registered at the program's last step, which waits while the previous result stalls.
// Synchronous reset loads the default gains and geometry and clears all speeds and integrators.
module two_wheel_pi_speed_controller_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int DRIVE_LIMIT = 255
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_op,
  input  logic signed [tpsc_pkg::DELTA_W-1:0]   in_count_delta_one,
  input  logic signed [tpsc_pkg::DELTA_W-1:0]   in_count_delta_two,
  input  logic signed [tpsc_pkg::SPEED_W-1:0]   in_linear_speed,
  input  logic signed [tpsc_pkg::SPEED_W-1:0]   in_angular_speed,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tpsc_pkg::OUT_W-1:0]     out_drive_one,
  output logic signed [tpsc_pkg::OUT_W-1:0]     out_drive_two,
  input  logic                                  cfg_we,
  input  logic [tpsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpsc_pkg::REG_W-1:0]            cfg_data
);
  import tpsc_pkg::*;

  localparam int ENC_SHIFT = 32 - FRAC_BITS;
  localparam int TURN_W    = 56 - FRAC_BITS;
  localparam int SUM_W     = TURN_W + 1;
  localparam int ACC_W     = 58 - FRAC_BITS;
  localparam int QW        = ACC_W - FRAC_BITS;
  localparam int CMP_W     = (QW > 18) ? QW : 18;

  // configuration
  logic [REG_W-1:0] prop_gain_one_r, integ_gain_one_r;
  logic [REG_W-1:0] prop_gain_two_r, integ_gain_two_r;
  logic [REG_W-1:0] half_track_r, inv_wheel_radius_r;

  // latched input word
  logic signed [DELTA_W-1:0] delta_one_r, delta_two_r;
  logic signed [SPEED_W-1:0] lin_r, ang_r;

  // controller state
  logic signed [31:0] measured_one_r, measured_two_r;
  logic signed [31:0] target_one_r, target_two_r;
  logic signed [31:0] integ_one_r, integ_two_r;

  // scratch
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [TURN_W-1:0]  turn_r;
  logic signed [31:0]        opa_r;
  logic signed [MUL_A_W-1:0] err_one_r, err_two_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [OUT_W-1:0]          drv_one_r, drv_two_r;

  // output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_drive_one_r, out_drive_two_r;

  ctl_t ctl;
  logic busy, seq_emit, accept, out_hold;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  sh;
  logic signed [SUM_W-1:0]   vt_sum, vt_dif;

  logic signed [QW-1:0]    q_floor, q_trunc;
  logic signed [CMP_W-1:0] q_ext, lim_pos, lim_neg, drv_sat, drv_neg;

  assign accept   = in_valid && !busy;
  assign in_stall = busy;
  assign out_hold = out_valid_r && out_stall;

  tpsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && (in_op != OP_NONE)),
    .op       (in_op),
    .out_hold (out_hold),
    .ctl      (ctl),
    .busy     (busy),
    .emit     (seq_emit)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_one_r    <= KP1_RST;
      integ_gain_one_r   <= KI1_RST;
      prop_gain_two_r    <= KP2_RST;
      integ_gain_two_r   <= KI2_RST;
      half_track_r       <= HT_RST;
      inv_wheel_radius_r <= INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KP1: prop_gain_one_r    <= cfg_data;
        CFG_KI1: integ_gain_one_r   <= cfg_data;
        CFG_KP2: prop_gain_two_r    <= cfg_data;
        CFG_KI2: integ_gain_two_r   <= cfg_data;
        CFG_HT:  half_track_r       <= cfg_data;
        CFG_INV: inv_wheel_radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delta_one_r <= in_count_delta_one;
      delta_two_r <= in_count_delta_two;
      lin_r       <= in_linear_speed;
      ang_r       <= in_angular_speed;
    end
  end

  // shared multiplier
  always_comb begin
    case (ctl.a_sel)
      ASEL_D1:   mul_a = MUL_A_W'(delta_one_r);
      ASEL_D2:   mul_a = MUL_A_W'(delta_two_r);
      ASEL_W:    mul_a = MUL_A_W'(ang_r);
      ASEL_OPA:  mul_a = MUL_A_W'(opa_r);
      ASEL_ERR1: mul_a = err_one_r;
      ASEL_ERR2: mul_a = err_two_r;
      default:   mul_a = '0;
    endcase
    case (ctl.b_sel)
      BSEL_PI:  mul_b = PI18_Q32;
      BSEL_HT:  mul_b = MUL_B_W'(half_track_r);
      BSEL_INV: mul_b = MUL_B_W'(inv_wheel_radius_r);
      BSEL_KP1: mul_b = MUL_B_W'(prop_gain_one_r);
      BSEL_KI1: mul_b = MUL_B_W'(integ_gain_one_r);
      BSEL_KP2: mul_b = MUL_B_W'(prop_gain_two_r);
      BSEL_KI2: mul_b = MUL_B_W'(integ_gain_two_r);
      default:  mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // floor scaling of the registered product
  assign sh = ctl.sh_enc ? (prod_r >>> ENC_SHIFT) : (prod_r >>> FRAC_BITS);

  assign vt_sum = SUM_W'(lin_r) + SUM_W'(turn_r);
  assign vt_dif = SUM_W'(lin_r) - SUM_W'(turn_r);

  // drive: truncate toward zero, then clamp
  assign q_floor = QW'(acc_r >>> FRAC_BITS);
  assign q_trunc = (acc_r[ACC_W-1] && (acc_r[FRAC_BITS-1:0] != '0)) ?
                   q_floor + QW'(1) : q_floor;
  assign q_ext   = CMP_W'(q_trunc);
  assign lim_pos = CMP_W'(DRIVE_LIMIT);
  assign lim_neg = -lim_pos;
  assign drv_sat = (q_ext > lim_pos) ? lim_pos : ((q_ext < lim_neg) ? lim_neg : q_ext);
  assign drv_neg = -drv_sat;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measured_one_r <= '0;
      measured_two_r <= '0;
      target_one_r   <= '0;
      target_two_r   <= '0;
      integ_one_r    <= '0;
      integ_two_r    <= '0;
    end else begin
      case (ctl.wr)
        WR_MEAS1: measured_one_r <= sat32(sh);
        WR_MEAS2: measured_two_r <= sat32(sh);
        WR_TGT1:  target_one_r   <= sat32(sh);
        WR_TGT2:  target_two_r   <= sat32(sh);
        WR_INT1:  integ_one_r    <= sat32(PROD_W'(integ_one_r) + sh);
        WR_INT2:  integ_two_r    <= sat32(PROD_W'(integ_two_r) + sh);
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_p;
    end
    case (ctl.wr)
      WR_TURN:    turn_r <= TURN_W'(sh);
      WR_OPA_ADD: opa_r  <= sat32(PROD_W'(vt_sum));
      WR_OPA_SUB: opa_r  <= sat32(PROD_W'(vt_dif));
      WR_ERR: begin
        err_one_r <= MUL_A_W'(target_one_r) - MUL_A_W'(measured_one_r);
        err_two_r <= MUL_A_W'(target_two_r) - MUL_A_W'(measured_two_r);
      end
      WR_ACC1:    acc_r  <= ACC_W'(sh) + ACC_W'(integ_one_r);
      WR_ACC2:    acc_r  <= ACC_W'(sh) + ACC_W'(integ_two_r);
      default: ;
    endcase
    case (ctl.drv)
      DRV_ONE: drv_one_r <= drv_neg[OUT_W-1:0];
      DRV_TWO: drv_two_r <= drv_sat[OUT_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_emit) begin
      out_drive_one_r <= drv_one_r;
      out_drive_two_r <= drv_two_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive_one = out_drive_one_r;
  assign out_drive_two = out_drive_two_r;

  // encoder word: busy for exactly three steps
  a_enc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_ENC) |=> in_stall ##3 !in_stall)
    else $error("encoder word did not finish in three steps");

  // tick word with a free output gives its result after the full program
  a_tick_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_TICK && !out_valid) |-> ##9 out_valid)
    else $error("tick result missing after program end");

  // a result only comes out of a running program
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result emitted while sequencer idle");

endmodule

// File: sim/tb_two_wheel_pi_speed_controller_unit.sv
// Self-checking testbench for the two-wheel PI speed controller unit.
module tb_two_wheel_pi_speed_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsc_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam longint DRIVE_LIMIT = 255;
  localparam longint PI_18_Q32 = 64'sd749613206;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  localparam logic [REG_W-1:0] DEF_KP_ONE = 24'd6554;
  localparam logic [REG_W-1:0] DEF_KI_ONE = 24'd13107;
  localparam logic [REG_W-1:0] DEF_KP_TWO = 24'd39322;
  localparam logic [REG_W-1:0] DEF_KI_TWO = 24'd26214;
  localparam logic [REG_W-1:0] DEF_HALF_TRACK = 24'd8520;
  localparam logic [REG_W-1:0] DEF_INV_RADIUS = 24'd1310720;
  localparam logic [REG_W-1:0] REG_MAX = 24'hFFFFFF;

  // indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct packed {
    logic signed [OUT_W-1:0] one;
    logic signed [OUT_W-1:0] two;
  } drive_pair_t;

  class drive_tracker;
    logic [REG_W-1:0] kp_one, ki_one, kp_two, ki_two, half_trk, inv_rad;
    int meas_one, meas_two, tgt_one, tgt_two, acc_one, acc_two;
    drive_pair_t pending_drives[$];
    int errors;

    function new();
      kp_one = DEF_KP_ONE;
      ki_one = DEF_KI_ONE;
      kp_two = DEF_KP_TWO;
      ki_two = DEF_KI_TWO;
      half_trk = DEF_HALF_TRACK;
      inv_rad = DEF_INV_RADIUS;
      meas_one = 0;
      meas_two = 0;
      tgt_one = 0;
      tgt_two = 0;
      acc_one = 0;
      acc_two = 0;
      errors = 0;
    endfunction

    function int clamp_word(input longint v);
      if (v > WORD_MAX) return int'(WORD_MAX);
      if (v < WORD_MIN) return int'(WORD_MIN);
      return int'(v);
    endfunction

    function int wheel_speed(input longint sum);
      int s;
      s = clamp_word(sum);
      return clamp_word((longint'(s) * longint'(inv_rad)) >>> FRAC_BITS);
    endfunction

    // integrator first, then P + I truncated toward zero and limited
    function int pi_update(input int tgt, input int meas, input logic [REG_W-1:0] kp,
                           input logic [REG_W-1:0] ki, inout int acc);
      longint err;
      longint u;
      err = longint'(tgt) - longint'(meas);
      acc = clamp_word(longint'(acc) + ((longint'(ki) * err) >>> FRAC_BITS));
      u = ((longint'(kp) * err) >>> FRAC_BITS) + longint'(acc);
      if (u < 0) u = -((-u) >>> FRAC_BITS);
      else u = u >>> FRAC_BITS;
      if (u > DRIVE_LIMIT) u = DRIVE_LIMIT;
      if (u < -DRIVE_LIMIT) u = -DRIVE_LIMIT;
      return int'(u);
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      case (idx)
        CFG_KP1: kp_one = val;
        CFG_KI1: ki_one = val;
        CFG_KP2: kp_two = val;
        CFG_KI2: ki_two = val;
        CFG_HT: half_trk = val;
        CFG_INV: inv_rad = val;
        default: ;
      endcase
    endfunction

    function void absorb_word(input logic [1:0] op, input logic signed [DELTA_W-1:0] d1,
                              input logic signed [DELTA_W-1:0] d2,
                              input logic signed [SPEED_W-1:0] v,
                              input logic signed [SPEED_W-1:0] w);
      longint turn;
      int a;
      int b;
      drive_pair_t x;
      case (op)
        OP_ENC: begin
          meas_one = clamp_word((longint'(d1) * PI_18_Q32) >>> (32 - FRAC_BITS));
          meas_two = clamp_word((longint'(d2) * PI_18_Q32) >>> (32 - FRAC_BITS));
        end
        OP_TWIST: begin
          turn = (longint'(half_trk) * longint'(w)) >>> FRAC_BITS;
          tgt_one = wheel_speed(longint'(v) + turn);
          tgt_two = wheel_speed(longint'(v) - turn);
        end
        OP_TICK: begin
          a = pi_update(tgt_one, meas_one, kp_one, ki_one, acc_one);
          b = pi_update(tgt_two, meas_two, kp_two, ki_two, acc_two);
          x.one = OUT_W'(-a);
          x.two = OUT_W'(b);
          pending_drives.push_back(x);
        end
        default: ;
      endcase
    endfunction

    function void check_drive(input logic signed [OUT_W-1:0] one,
                              input logic signed [OUT_W-1:0] two);
      drive_pair_t x;
      if (pending_drives.size() == 0) begin
        $error("drive word with none expected: drive_one %0d drive_two %0d", one, two);
        errors++;
        return;
      end
      x = pending_drives.pop_front();
      if (one !== x.one) begin
        $error("drive_one: expected %0d, got %0d", x.one, one);
        errors++;
      end
      if (two !== x.two) begin
        $error("drive_two: expected %0d, got %0d", x.two, two);
        errors++;
      end
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_op;
  logic signed [DELTA_W-1:0] in_count_delta_one;
  logic signed [DELTA_W-1:0] in_count_delta_two;
  logic signed [SPEED_W-1:0] in_linear_speed;
  logic signed [SPEED_W-1:0] in_angular_speed;
  logic out_valid;
  logic out_stall;
  logic signed [OUT_W-1:0] out_drive_one;
  logic signed [OUT_W-1:0] out_drive_two;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  int cycles;

  drive_tracker tracker = new();

  two_wheel_pi_speed_controller_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_count_delta_one(in_count_delta_one),
    .in_count_delta_two(in_count_delta_two),
    .in_linear_speed(in_linear_speed),
    .in_angular_speed(in_angular_speed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive_one(out_drive_one),
    .out_drive_two(out_drive_two),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      tracker.absorb_word(in_op, in_count_delta_one, in_count_delta_two,
                          in_linear_speed, in_angular_speed);
    end
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_drive(out_drive_one, out_drive_two);
    end
    if (rst_n && cfg_we) begin
      tracker.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [DELTA_W-1:0] pick_delta();
    int k;
    k = $urandom_range(9);
    case (k)
      0, 1, 2, 3, 4: return DELTA_W'($urandom_range(128) - 64);
      5, 6: return DELTA_W'($urandom);
      7: return 16'h7FFF;
      8: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    int k;
    k = $urandom_range(9);
    case (k)
      0, 1, 2, 3: return SPEED_W'($urandom_range(32'h80000) - 32'h40000);
      4, 5: return SPEED_W'($urandom_range(32'h2000000) - 32'h1000000);
      6, 7: return SPEED_W'($urandom);
      8: return 32'h7FFFFFFF;
      default: return 32'h80000000;
    endcase
  endfunction

  // leaves valid high after the accepting edge; the next call lowers or reloads it
  task automatic send_word(input logic [1:0] op, input logic [DELTA_W-1:0] d1,
                           input logic [DELTA_W-1:0] d2, input logic [SPEED_W-1:0] v,
                           input logic [SPEED_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_count_delta_one <= d1;
    in_count_delta_two <= d2;
    in_linear_speed <= v;
    in_angular_speed <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random(output bit counted);
    int r;
    logic [1:0] op;
    r = $urandom_range(99);
    if (r < 5) op = OP_NONE;
    else if (r < 37) op = OP_ENC;
    else if (r < 67) op = OP_TWIST;
    else op = OP_TICK;
    counted = (op != OP_NONE);
    send_word(op, pick_delta(), pick_delta(), pick_speed(), pick_speed());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // wait for every expected drive word and for the block to finish its last word
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input int ph);
    case (ph)
      0: ;
      1: begin
        write_reg(CFG_KP1, REG_MAX);
        write_reg(CFG_KI1, REG_MAX);
        write_reg(CFG_KP2, REG_MAX);
        write_reg(CFG_KI2, REG_MAX);
        write_reg(CFG_HT, REG_MAX);
        write_reg(CFG_INV, REG_MAX);
        write_reg(CFG_SPARE_LO, REG_W'($urandom));
        write_reg(CFG_SPARE_HI, REG_W'($urandom));
      end
      2: begin
        write_reg(CFG_KP1, '0);
        write_reg(CFG_KI1, '0);
        write_reg(CFG_KP2, '0);
        write_reg(CFG_KI2, '0);
        write_reg(CFG_HT, '0);
        write_reg(CFG_INV, '0);
      end
      3: begin
        write_reg(CFG_KP1, REG_W'($urandom));
        write_reg(CFG_KI1, REG_W'($urandom));
        write_reg(CFG_KP2, REG_W'($urandom));
        write_reg(CFG_KI2, REG_W'($urandom));
        write_reg(CFG_HT, REG_W'($urandom));
        write_reg(CFG_INV, REG_W'($urandom));
      end
      5: begin
        write_reg(CFG_KP1, DEF_KP_ONE);
        write_reg(CFG_KI1, DEF_KI_ONE);
        write_reg(CFG_KP2, DEF_KP_TWO);
        write_reg(CFG_KI2, DEF_KI_TWO);
        write_reg(CFG_HT, DEF_HALF_TRACK);
        write_reg(CFG_INV, DEF_INV_RADIUS);
      end
      6: begin
        write_reg(CFG_KP1, REG_MAX);
        write_reg(CFG_KI1, '0);
        write_reg(CFG_KP2, '0);
        write_reg(CFG_KI2, REG_MAX);
        write_reg(CFG_HT, REG_MAX);
        write_reg(CFG_INV, 24'd1);
      end
      default: begin
        // gains and geometry in a range where drives mostly stay unsaturated
        write_reg(CFG_KP1, REG_W'($urandom_range(32'h20000)));
        write_reg(CFG_KI1, REG_W'($urandom_range(32'h20000)));
        write_reg(CFG_KP2, REG_W'($urandom_range(32'h20000)));
        write_reg(CFG_KI2, REG_W'($urandom_range(32'h20000)));
        write_reg(CFG_HT, REG_W'($urandom_range(32'h10000)));
        write_reg(CFG_INV, REG_W'($urandom_range(32'h200000, 32'h10000)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'h00010000, 32'h00008000);
    send_word(OP_ENC, 16'd57, 16'd50, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_ENC, 16'hFFC7, 16'hFFFF, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'hFFFF0000, 32'hFFFFC000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_ENC, 16'h7FFF, 16'h8000, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_ENC, 16'h8000, 16'h7FFF, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'h80000000, 32'h80000000);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'h80000000, 32'h7FFFFFFF);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_NONE, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_ENC, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TWIST, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_word(OP_TICK, 16'h0000, 16'h0000, 32'h0, 32'h0);
  endtask

  initial begin
    int ph;
    int sent;
    int n;
    bit counted;
    cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ENC;
    in_count_delta_one = '0;
    in_count_delta_two = '0;
    in_linear_speed = '0;
    in_angular_speed = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_KP1;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      apply_settings(ph);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        send_random(counted);
        if (counted) sent++;
      end
    end

    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && tracker.pending() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d drive words never arrived", tracker.pending());
      tracker.errors++;
    end

    if (tracker.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
